### sv/encoder_velocity_median_lowpass_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder velocity block
// Short forms for clocked assertions that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ENCODER_VELOCITY_MEDIAN_LOWPASS_MACROS_SVH
`define ENCODER_VELOCITY_MEDIAN_LOWPASS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVML_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EVML_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/evml_pkg.sv
// ----------------------------------------------------------------------------
// Encoder velocity package
// Types, command codes, register indexes and arithmetic constants shared by
// the front end, the operation queue and the execution back end.
// ----------------------------------------------------------------------------
package evml_pkg;

  // Command codes of an input item.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration port layout and register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT  = 1'b1;

  // Register reset values.
  localparam logic [15:0] CPR_RESET    = 16'd1801;
  localparam logic [15:0] WEIGHT_RESET = 16'd13107;

  // Speed numerator 360 * 256 * 1e6 and angle numerator 360 * 256.
  localparam int unsigned SPD_NUM_W = 37;
  localparam int unsigned SPD_DEN_W = 48;
  localparam int unsigned ANG_NUM_W = 49;
  localparam int unsigned ANG_DEN_W = 16;
  localparam logic [SPD_NUM_W-1:0] SPEED_NUM = 37'd92160000000;
  localparam logic [16:0]          ANGLE_K   = 17'd92160;

  // Limits of the 32-bit signed result range, as bit patterns.
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Default depth of the queue between front end and back end.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // One classified operation as it travels through the queue.
  typedef struct packed {
    logic        cmd;
    logic [31:0] period;
    logic        fwd;
  } op_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_START,
    B_WAIT,
    B_DONE
  } back_state_t;

endpackage

### sv/evml_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per clock, NUM_W steps per operation.
// ----------------------------------------------------------------------------
module evml_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] steps;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_hold;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem, quo[NUM_W-1]};
    rem_diff  = rem_shift - {1'b0, den_hold};
    fits      = rem_shift >= {1'b0, den_hold};
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CNT_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - CNT_W'(1);
      if (steps == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= num;
      rem      <= '0;
      den_hold <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

endmodule

### sv/evml_front.sv
// ----------------------------------------------------------------------------
// Encoder velocity front end
// Accepts input beats, measures the edge period and pushes one classified
// operation per beat into the queue.
// ----------------------------------------------------------------------------
module evml_front import evml_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        cmd,
  input  logic [31:0] timestamp_us,
  input  logic        direction_level,
  input  q_stat_t     q_stat,
  output logic        push,
  output op_t         push_op
);

  logic [31:0] last_edge_time;

  // Take a beat whenever the queue has room.
  assign item_stall = q_stat.full;
  assign push       = item_valid && !q_stat.full;

  // The period wraps with the free-running timestamp.
  always_comb begin
    push_op.cmd    = cmd;
    push_op.period = timestamp_us - last_edge_time;
    push_op.fwd    = direction_level;
  end

  // Only edges move the reference time.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
    end else if (push && (cmd == CMD_EDGE)) begin
      last_edge_time <= timestamp_us;
    end
  end

endmodule

### sv/evml_queue.sv
// ----------------------------------------------------------------------------
// Encoder velocity operation queue
// Small first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module evml_queue import evml_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head,
  output q_stat_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (fill == CNT_W'(DEPTH));
  assign q_stat.empty = (fill == '0);

  // Pointers advance with wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

### sv/evml_back.sv
// ----------------------------------------------------------------------------
// Encoder velocity back end
// Holds the configuration and the filter state, runs the speed and angle
// divisions and the low-pass update, and drives the result register.
// ----------------------------------------------------------------------------
module evml_back import evml_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  q_stat_t               q_stat,
  input  op_t                   head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [31:0]    raw_speed,
  output logic signed [31:0]    median_speed,
  output logic signed [31:0]    filtered_speed,
  output logic signed [31:0]    edge_count,
  output logic signed [31:0]    angle
);

  back_state_t state, state_next;

  logic [15:0] counts_per_rev;
  logic [15:0] filter_weight;

  // Architectural state.
  logic [31:0] position_count;
  logic [31:0] speed_prev1;
  logic [31:0] speed_prev2;
  logic [31:0] speed_median;
  logic [31:0] speed_filtered;
  logic [31:0] speed_raw;

  // Working registers of the operation in flight.
  op_t                    op;
  logic [31:0]            count_new;
  logic [SPD_DEN_W-1:0]   spd_den;
  logic [ANG_NUM_W-1:0]   ang_num;
  logic                   ang_neg;
  logic                   ang_zero;
  logic signed [49:0]     filt_prod;

  logic                   div_start;
  logic                   spd_busy;
  logic                   ang_busy;
  logic [SPD_NUM_W-1:0]   spd_quo;
  logic [ANG_NUM_W-1:0]   ang_quo;
  logic                   out_free;
  logic                   commit;

  // Multiply stage signals.
  logic [31:0]            cnt_mag;
  logic [SPD_DEN_W-1:0]   den_c;
  logic [ANG_NUM_W-1:0]   ang_c;
  logic signed [32:0]     diff_s;
  logic signed [16:0]     weight_s;
  logic signed [49:0]     prod_c;

  // Finish stage signals.
  logic                   spd_sat;
  logic [31:0]            spd_mag;
  logic [31:0]            spd_val;
  logic [31:0]            med_val;
  logic signed [49:0]     rnd_s;
  logic signed [33:0]     step_s;
  logic signed [34:0]     sum_s;
  logic [31:0]            filt_val;
  logic [31:0]            angle_val;

  // True median of three signed values; ties fall out of the compares.
  function automatic logic [31:0] median3(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic signed [31:0] c);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      r = lo;
    end else if (c >= hi) begin
      r = hi;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Clamp a 35-bit signed sum to the 32-bit signed range.
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if ((v[34:31] != 4'b0000) && (v[34:31] != 4'b1111)) begin
      r = v[34] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_RESET;
      filter_weight  <= WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COUNTS_PER_REV: counts_per_rev <= cfg_data;
        REG_FILTER_WEIGHT:  filter_weight  <= cfg_data;
      endcase
    end
  end

  // Speed and angle divisions run side by side.
  evml_div #(
    .NUM_W (SPD_NUM_W),
    .DEN_W (SPD_DEN_W)
  ) u_spd_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (SPEED_NUM),
    .den   (spd_den),
    .busy  (spd_busy),
    .quo   (spd_quo)
  );

  evml_div #(
    .NUM_W (ANG_NUM_W),
    .DEN_W (ANG_DEN_W)
  ) u_ang_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ang_num),
    .den   (counts_per_rev),
    .busy  (ang_busy),
    .quo   (ang_quo)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The result register is free when empty or being taken this cycle.
  assign out_free = !result_valid || !result_stall;

  // Sequencer next state and control.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_START;
      end
      B_START: begin
        div_start  = 1'b1;
        state_next = B_WAIT;
      end
      B_WAIT: begin
        if (!spd_busy && !ang_busy) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Multiply stage: speed denominator, angle numerator and filter product.
  always_comb begin
    cnt_mag  = count_new[31] ? (~count_new + 32'd1) : count_new;
    den_c    = SPD_DEN_W'(op.period) * SPD_DEN_W'(counts_per_rev);
    ang_c    = ANG_NUM_W'(ANGLE_K) * ANG_NUM_W'(cnt_mag);
    diff_s   = {speed_median[31], speed_median} - {speed_filtered[31], speed_filtered};
    weight_s = {1'b0, filter_weight};
    prod_c   = diff_s * weight_s;
  end

  // Working registers load on pop and in the multiply stage.
  always_ff @(posedge clk) begin
    if (pop) begin
      op <= head;
      if (head.cmd == CMD_EDGE) begin
        count_new <= head.fwd ? position_count + 32'd1 : position_count - 32'd1;
      end else begin
        count_new <= position_count;
      end
    end
    if (state == B_MUL) begin
      spd_den   <= den_c;
      ang_num   <= ang_c;
      ang_neg   <= count_new[31];
      ang_zero  <= (count_new == '0);
      filt_prod <= prod_c;
    end
  end

  // Finish stage: saturate the quotients, take the median, update the filter.
  always_comb begin
    spd_sat  = (spd_den == '0) || (spd_quo > SPD_NUM_W'(S32_MAX));
    spd_mag  = spd_sat ? S32_MAX : spd_quo[31:0];
    spd_val  = op.fwd ? spd_mag : (~spd_mag + 32'd1);
    med_val  = median3(spd_val, speed_prev1, speed_prev2);

    rnd_s    = filt_prod + 50'sd32768;
    step_s   = rnd_s[49:16];
    sum_s    = {{3{speed_filtered[31]}}, speed_filtered} + {step_s[33], step_s};
    filt_val = sat32(sum_s);

    if (ang_zero) begin
      angle_val = '0;
    end else if (counts_per_rev == '0) begin
      angle_val = ang_neg ? S32_MIN : S32_MAX;
    end else if (!ang_neg) begin
      angle_val = (ang_quo > ANG_NUM_W'(S32_MAX)) ? S32_MAX : ang_quo[31:0];
    end else begin
      angle_val = (ang_quo > ANG_NUM_W'(S32_MIN)) ? S32_MIN : (~ang_quo[31:0] + 32'd1);
    end
  end

  // Architectural state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      speed_prev1    <= '0;
      speed_prev2    <= '0;
      speed_median   <= '0;
      speed_filtered <= '0;
      speed_raw      <= '0;
    end else if (commit) begin
      if (op.cmd == CMD_EDGE) begin
        position_count <= count_new;
        speed_raw      <= spd_val;
        speed_median   <= med_val;
        speed_prev2    <= speed_prev1;
        speed_prev1    <= spd_val;
      end else begin
        speed_filtered <= filt_val;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      edge_count <= count_new;
      angle      <= angle_val;
      if (op.cmd == CMD_EDGE) begin
        raw_speed      <= spd_val;
        median_speed   <= med_val;
        filtered_speed <= speed_filtered;
      end else begin
        raw_speed      <= speed_raw;
        median_speed   <= speed_median;
        filtered_speed <= filt_val;
      end
    end
  end

endmodule

### sv/encoder_velocity_median_lowpass.sv
// ----------------------------------------------------------------------------
// Encoder velocity with median and low-pass filter
// Period-based encoder speed, three-sample median, first-order IIR and angle.
// ----------------------------------------------------------------------------
// Each input beat is either an encoder edge (timestamp and direction) or a
// filter tick, and yields exactly one result beat with the raw speed, the
// median speed, the filtered speed, the edge count and the shaft angle. Items
// are handled one at a time: the front end accepts beats into a short queue
// while it has room, and the back end spends most of an item in the 49-step
// angle division, which runs beside the 37-step speed division. Ticks take the
// same time as edges. The result register lets the back end work on the next
// item while the previous result is still waiting to be taken; a waiting
// result holds the back end only at its final step.
// Configuration writes are taken at any time but are meant for an idle block.
module encoder_velocity_median_lowpass import evml_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  cmd,
  input  logic [31:0]           timestamp_us,
  input  logic                  direction_level,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [31:0]    raw_speed,
  output logic signed [31:0]    median_speed,
  output logic signed [31:0]    filtered_speed,
  output logic signed [31:0]    edge_count,
  output logic signed [31:0]    angle
);

  q_stat_t q_stat;
  logic    push;
  op_t     push_op;
  logic    pop;
  op_t     head;

  // Front end: accept and classify.
  evml_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .cmd             (cmd),
    .timestamp_us    (timestamp_us),
    .direction_level (direction_level),
    .q_stat          (q_stat),
    .push            (push),
    .push_op         (push_op)
  );

  // Operation queue.
  evml_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // Back end: arithmetic, state and result register.
  evml_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .raw_speed      (raw_speed),
    .median_speed   (median_speed),
    .filtered_speed (filtered_speed),
    .edge_count     (edge_count),
    .angle          (angle)
  );

endmodule

### sv/evml_checker.sv
// ----------------------------------------------------------------------------
// Encoder velocity port checker
// Watches the top-level ports and checks result ordering and consistency.
// ----------------------------------------------------------------------------
`include "encoder_velocity_median_lowpass_macros.svh"

module evml_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] raw_speed,
  input logic [31:0] median_speed,
  input logic [31:0] edge_count
);

  logic       in_beat;
  logic       out_beat;
  logic [7:0] pending;
  logic       have_prev;
  logic [31:0] prev_count;
  logic [31:0] prev_raw;
  logic [31:0] prev_med;

  assign in_beat  = item_valid && !item_stall;
  assign out_beat = result_valid && !result_stall;

  // Items accepted whose result beat has not gone out yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_beat && !out_beat) begin
      pending <= pending + 8'd1;
    end else if (out_beat && !in_beat) begin
      pending <= pending - 8'd1;
    end
  end

  // Last result beat seen.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_beat) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_count <= edge_count;
      prev_raw   <= raw_speed;
      prev_med   <= median_speed;
    end
  end

  // A stalled result stays valid, with its edge count and raw speed unchanged.
  `EVML_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall,
                    result_valid && $stable(edge_count) && $stable(raw_speed),
                    "stalled result changed")

  // Every result beat belongs to an item accepted earlier.
  `EVML_ASSERT_NOW(a_result_has_item, clk, rst, out_beat, pending != 8'd0,
                   "result beat without an accepted item")

  // The edge count moves by at most one step between result beats.
  `EVML_ASSERT_NOW(a_count_step, clk, rst, out_beat && have_prev,
                   ((edge_count - prev_count) == 32'd1) || (edge_count == prev_count) ||
                   ((prev_count - edge_count) == 32'd1),
                   "edge count jumped")

  // A tick leaves the raw and median speeds as they were.
  `EVML_ASSERT_NOW(a_tick_keeps_speed, clk, rst,
                   out_beat && have_prev && (edge_count == prev_count),
                   (raw_speed == prev_raw) && (median_speed == prev_med),
                   "tick changed the edge speeds")

endmodule

bind encoder_velocity_median_lowpass evml_checker u_evml_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .raw_speed    (raw_speed),
  .median_speed (median_speed),
  .edge_count   (edge_count)
);

### sim/tb_encoder_velocity_median_lowpass.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the encoder velocity block
// Drives edge and tick beats through the valid/stall handshake, predicts the
// raw, median and filtered speed, the edge count and the angle for every
// accepted beat, and compares each result beat field by field. A short
// directed table comes first, then random edge trains under several register
// settings and three idling patterns.
// ----------------------------------------------------------------------------
module tb_encoder_velocity_median_lowpass;
  import evml_pkg::*;

  // One result beat as the block reports it.
  typedef struct packed {
    logic signed [31:0] raw;
    logic signed [31:0] med;
    logic signed [31:0] filt;
    logic signed [31:0] cnt;
    logic signed [31:0] ang;
  } speed_report_t;

  // Rows of the directed table: a plain item, an item with a typed-in result,
  // or a register write.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  cmd;
    logic [31:0]           ts;
    logic                  dir;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [15:0]           reg_val;
    speed_report_t         want;
  } row_t;

  localparam logic signed [31:0] POS_LIMIT = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_LIMIT = 32'sh8000_0000;
  localparam longint unsigned SPEED_K = 64'd92160000000;
  localparam longint unsigned ANGLE_K = 64'd92160;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 350;
  localparam int unsigned ITEMS_PER_SETTING = 70;
  localparam int unsigned SETTLE_CYCLES = 60;

  localparam row_t PLAN [28] = '{
    '{ROW_CHECKED, CMD_TICK, 32'hFFFF_FFFF, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_CHECKED, CMD_EDGE, 32'h0000_0000, 1'b1, REG_COUNTS_PER_REV, 16'd0,
      '{POS_LIMIT, 32'sd0, 32'sd0, 32'sd1, 32'sd51}},
    '{ROW_CHECKED, CMD_EDGE, 32'h0000_0000, 1'b1, REG_COUNTS_PER_REV, 16'd0,
      '{POS_LIMIT, POS_LIMIT, 32'sd0, 32'sd2, 32'sd102}},
    '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0000_0001, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'hFFFF_FFFF, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0000_0009, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0000_0009, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0000_0009, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_CFG, CMD_EDGE, 32'h0, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'd500, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'd600, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'd600, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'd600, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_CFG, CMD_EDGE, 32'h0, 1'b0, REG_COUNTS_PER_REV, 16'hFFFF, '0},
    '{ROW_CFG, CMD_EDGE, 32'h0, 1'b0, REG_FILTER_WEIGHT, 16'hFFFF, '0},
    '{ROW_ITEM, CMD_TICK, 32'h5A5A_5A5A, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK, 32'hA5A5_A5A5, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_CFG, CMD_EDGE, 32'h0, 1'b0, REG_FILTER_WEIGHT, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_CFG, CMD_EDGE, 32'h0, 1'b0, REG_FILTER_WEIGHT, 16'h8000, '0},
    '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0001_2345, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_CFG, CMD_EDGE, 32'h0, 1'b0, REG_COUNTS_PER_REV, 16'd1, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0001_2346, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0001_2370, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_EDGE, 32'h0001_239B, 1'b1, REG_COUNTS_PER_REV, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, REG_COUNTS_PER_REV, 16'd0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic cmd = CMD_EDGE;
  logic [31:0] timestamp_us = '0;
  logic direction_level = 1'b0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COUNTS_PER_REV;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] raw_speed;
  logic signed [31:0] median_speed;
  logic signed [31:0] filtered_speed;
  logic signed [31:0] edge_count;
  logic signed [31:0] angle;

  // Predicted state of the block and its registers.
  logic [15:0] cpr_reg = CPR_RESET;
  logic [15:0] weight_reg = WEIGHT_RESET;
  logic [31:0] last_edge_us = '0;
  logic [31:0] pos_count = '0;
  logic signed [31:0] spd_hist1 = '0;
  logic signed [31:0] spd_hist2 = '0;
  logic signed [31:0] spd_med = '0;
  logic signed [31:0] spd_filt = '0;
  logic signed [31:0] spd_raw = '0;

  speed_report_t pending_reports[$];
  int unsigned err_count = 0;
  int unsigned beat_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic heading = 1'b1;

  encoder_velocity_median_lowpass DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .timestamp_us(timestamp_us),
    .direction_level(direction_level),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .raw_speed(raw_speed),
    .median_speed(median_speed),
    .filtered_speed(filtered_speed),
    .edge_count(edge_count),
    .angle(angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a wide signed value into the 32-bit result range.
  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > longint'(POS_LIMIT)) return POS_LIMIT;
    if (v < longint'(NEG_LIMIT)) return NEG_LIMIT;
    return v[31:0];
  endfunction

  // Median of three that stays correct when values are equal.
  function automatic logic signed [31:0] mid_of_three(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic signed [31:0] c);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  // Angle in 1/256 degree from the current count and pulses per turn.
  function automatic logic signed [31:0] shaft_angle();
    longint cnt;
    longint unsigned mag;
    longint q;
    cnt = longint'(signed'(pos_count));
    if (cnt == 0) return '0;
    if (cpr_reg == 0) return (cnt < 0) ? NEG_LIMIT : POS_LIMIT;
    mag = (cnt < 0) ? longint'(-cnt) : longint'(cnt);
    q = longint'((ANGLE_K * mag) / {48'd0, cpr_reg});
    return clamp_s32((cnt < 0) ? -q : q);
  endfunction

  // Advance the predicted state by one item and return the result it reports.
  function automatic speed_report_t predict_item(input logic c, input logic [31:0] ts,
                                                 input logic d);
    logic [31:0] period;
    longint unsigned den;
    longint unsigned mag;
    logic signed [31:0] spd;
    longint diff;
    longint prod;
    speed_report_t r;
    if (c == CMD_EDGE) begin
      period = ts - last_edge_us;
      den = {32'd0, period} * {48'd0, cpr_reg};
      if (den == 0) begin
        mag = longint'(POS_LIMIT);
      end else begin
        mag = SPEED_K / den;
        if (mag > longint'(POS_LIMIT)) mag = longint'(POS_LIMIT);
      end
      spd = d ? signed'(mag[31:0]) : -signed'(mag[31:0]);
      last_edge_us = ts;
      pos_count = d ? pos_count + 32'd1 : pos_count - 32'd1;
      spd_raw = spd;
      spd_med = mid_of_three(spd, spd_hist1, spd_hist2);
      spd_hist2 = spd_hist1;
      spd_hist1 = spd;
    end else begin
      // Rounded to nearest with ties upward: add half, then floor.
      diff = longint'(spd_med) - longint'(spd_filt);
      prod = diff * longint'({48'd0, weight_reg}) + 64'sd32768;
      spd_filt = clamp_s32(longint'(spd_filt) + (prod >>> 16));
    end
    r.raw = spd_raw;
    r.med = spd_med;
    r.filt = spd_filt;
    r.cnt = signed'(pos_count);
    r.ang = shaft_angle();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 50) $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got %0d, want %0d", beat_count, name,
                                got, want));
  endtask

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin
    speed_report_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing outstanding", beat_count));
      end else begin
        want = pending_reports.pop_front();
        compare_field("raw_speed", raw_speed, want.raw);
        compare_field("median_speed", median_speed, want.med);
        compare_field("filtered_speed", filtered_speed, want.filt);
        compare_field("edge_count", edge_count, want.cnt);
        compare_field("angle", angle, want.ang);
      end
      beat_count++;
    end
  end

  // Result-side stall pattern.
  always @(posedge clk) begin
    result_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Send one item beat, idling cycle by cycle at the sender's rate, and record
  // its prediction.
  task automatic send_item(input logic c, input logic [31:0] ts, input logic d,
                           input logic use_typed, input speed_report_t typed);
    speed_report_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    timestamp_us <= ts;
    direction_level <= d;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = predict_item(c, ts, d);
    pending_reports.push_back(use_typed ? typed : predicted);
  endtask

  task automatic wait_results_drained();
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Register writes only happen once every outstanding result has come back.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    wait_results_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_COUNTS_PER_REV) cpr_reg = val;
    else weight_reg = val;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Random register setting, biased toward the extremes.
  task automatic pick_setting();
    logic [15:0] cpr_val;
    logic [15:0] w_val;
    case ($urandom_range(9))
      0: cpr_val = 16'd1;
      1: cpr_val = 16'hFFFF;
      2: cpr_val = 16'd0;
      3: cpr_val = CPR_RESET;
      4, 5, 6: cpr_val = 16'($urandom_range(1, 64));
      default: cpr_val = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(7))
      0: w_val = 16'd0;
      1: w_val = 16'hFFFF;
      2: w_val = 16'h8000;
      default: w_val = 16'($urandom);
    endcase
    write_register(REG_COUNTS_PER_REV, cpr_val);
    write_register(REG_FILTER_WEIGHT, w_val);
  endtask

  // Mostly edge trains with plausible periods, with ticks and noise mixed in.
  task automatic send_random_item();
    int unsigned pick;
    logic [31:0] period;
    if ($urandom_range(3) == 0) begin
      send_item(CMD_TICK, $urandom, 1'($urandom), 1'b0, '0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) period = '0;
      else if (pick < 30) period = $urandom_range(1, 64);
      else if (pick < 75) period = $urandom_range(65, 200000);
      else if (pick < 90) period = $urandom_range(200001, 1 << 24);
      else period = $urandom;
      if ($urandom_range(9) == 0) heading = ~heading;
      send_item(CMD_EDGE, last_edge_us + period, heading, 1'b0, '0);
    end
  endtask

  // Main sequence: reset, directed table, then three idling phases.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 59;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG)
        write_register(PLAN[i].reg_idx, PLAN[i].reg_val);
      else
        send_item(PLAN[i].cmd, PLAN[i].ts, PLAN[i].dir, PLAN[i].kind == ROW_CHECKED,
                  PLAN[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 7 : 0;
      for (int k = 0; k < RANDOM_ITEMS_PER_PHASE; k++) begin
        if (k % ITEMS_PER_SETTING == 0) pick_setting();
        send_random_item();
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
